// File: src/cpvpid_pkg.sv
// package: types, constants and microprogram of the cascaded position/velocity controller
package cpvpid_pkg;

   localparam int STEP_W = 4;
   localparam int CSR_W = 24;
   localparam int GAIN_W = 24;
   localparam int MULB_W = 18;
   localparam int PROD_W = GAIN_W + MULB_W;
   localparam int ACC_W = 64;
   localparam int LP_W = 21;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE   = 4'd0;
   localparam step_type STEP_LP_POS = 4'd1;
   localparam step_type STEP_LP_SPD = 4'd2;
   localparam step_type STEP_MUL_KP = 4'd3;
   localparam step_type STEP_MUL_KI = 4'd4;
   localparam step_type STEP_MUL_KD = 4'd5;
   localparam step_type STEP_OUTER  = 4'd6;
   localparam step_type STEP_MUL_LO = 4'd7;
   localparam step_type STEP_MUL_HI = 4'd8;
   localparam step_type STEP_SUM_HI = 4'd9;
   localparam step_type STEP_FINISH = 4'd10;

   typedef enum logic [2:0] {
      CSR_SETPOINT,
      CSR_POS_KP,
      CSR_POS_KI,
      CSR_SPD_KP,
      CSR_SPD_KD,
      CSR_INT_LIMIT,
      CSR_BAND_LOW,
      CSR_BAND_HIGH
   } csr_idx_type;

   localparam logic [9:0]         RST_SETPOINT  = 10'd0;
   localparam logic [GAIN_W-1:0]  RST_POS_KP    = 24'd25600;
   localparam logic [GAIN_W-1:0]  RST_GAIN_ZERO = 24'd0;
   localparam logic [14:0]        RST_INT_LIMIT = 15'd10000;
   localparam logic [7:0]         RST_BAND_LOW  = 8'd105;
   localparam logic [7:0]         RST_BAND_HIGH = 8'd115;

   localparam logic [1:0] TURN_NONE  = 2'b00;
   localparam logic [1:0] TURN_RIGHT = 2'b01;
   localparam logic [1:0] TURN_LEFT  = 2'b11;

   // floor(m/10) = (m * 838861) >> 23, exact for m below 2^22
   localparam logic [19:0] DIV10_MULT  = 20'd838861;
   localparam int          DIV10_SHIFT = 23;

   typedef enum logic [1:0] {HOLD_NONE, HOLD_REQ, HOLD_RSP} hold_type;
   typedef enum logic [2:0] {
      ACT_NONE, ACT_CAPTURE, ACT_LP_POS, ACT_LP_SPD, ACT_OUTER, ACT_FINISH
   } act_type;
   typedef enum logic [1:0] {MA_POS_KP, MA_POS_KI, MA_SPD_KP, MA_SPD_KD} mula_type;
   typedef enum logic [2:0] {
      MB_FPE, MB_INTEG, MB_ACCEL, MB_DIFF_LO, MB_DIFF_HI
   } mulb_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_type;
   typedef enum logic [1:0] {SH_0, SH_8, SH_24} shift_type;

   typedef struct packed {
      step_type  next;
      hold_type  hold;
      act_type   act;
      mula_type  ma;
      mulb_type  mb;
      acc_type   acc;
      shift_type sh;
   } ctrl_word_type;

   function automatic ctrl_word_type cw(input step_type nxt, input hold_type hld,
                                        input act_type act, input mula_type ma,
                                        input mulb_type mb, input acc_type acc,
                                        input shift_type sh);
      ctrl_word_type w;
      w.next = nxt;
      w.hold = hld;
      w.act  = act;
      w.ma   = ma;
      w.mb   = mb;
      w.acc  = acc;
      w.sh   = sh;
      return w;
   endfunction

   function automatic ctrl_word_type ucode(input step_type s);
      ctrl_word_type w;
      case (s)
         STEP_IDLE:   w = cw(STEP_LP_POS, HOLD_REQ, ACT_CAPTURE, MA_POS_KP, MB_FPE,
                             ACC_HOLD, SH_0);
         STEP_LP_POS: w = cw(STEP_LP_SPD, HOLD_NONE, ACT_LP_POS, MA_POS_KP, MB_FPE,
                             ACC_HOLD, SH_0);
         STEP_LP_SPD: w = cw(STEP_MUL_KP, HOLD_NONE, ACT_LP_SPD, MA_POS_KP, MB_FPE,
                             ACC_HOLD, SH_0);
         STEP_MUL_KP: w = cw(STEP_MUL_KI, HOLD_NONE, ACT_NONE, MA_POS_KP, MB_FPE,
                             ACC_HOLD, SH_0);
         STEP_MUL_KI: w = cw(STEP_MUL_KD, HOLD_NONE, ACT_NONE, MA_POS_KI, MB_INTEG,
                             ACC_LOAD, SH_0);
         STEP_MUL_KD: w = cw(STEP_OUTER, HOLD_NONE, ACT_NONE, MA_SPD_KD, MB_ACCEL,
                             ACC_ADD, SH_0);
         STEP_OUTER:  w = cw(STEP_MUL_LO, HOLD_NONE, ACT_OUTER, MA_SPD_KP, MB_DIFF_LO,
                             ACC_LOAD, SH_0);
         STEP_MUL_LO: w = cw(STEP_MUL_HI, HOLD_NONE, ACT_NONE, MA_SPD_KP, MB_DIFF_LO,
                             ACC_HOLD, SH_0);
         STEP_MUL_HI: w = cw(STEP_SUM_HI, HOLD_NONE, ACT_NONE, MA_SPD_KP, MB_DIFF_HI,
                             ACC_ADD, SH_8);
         STEP_SUM_HI: w = cw(STEP_FINISH, HOLD_NONE, ACT_NONE, MA_SPD_KP, MB_DIFF_HI,
                             ACC_ADD, SH_24);
         STEP_FINISH: w = cw(STEP_IDLE, HOLD_RSP, ACT_FINISH, MA_SPD_KP, MB_DIFF_HI,
                             ACC_HOLD, SH_0);
         default:     w = cw(STEP_IDLE, HOLD_NONE, ACT_NONE, MA_POS_KP, MB_FPE,
                             ACC_HOLD, SH_0);
      endcase
      return w;
   endfunction

endpackage

// File: src/cascaded_position_velocity_pid.sv
// top level: microcoded cascaded position/velocity controller with turn detection
//
// One transaction on the req_ channel is one control tick: distance, two encoder
// counts, forward acceleration and target x. One transaction on the rsp_ channel
// returns motor drive, outer loop output and the turn request/direction.
// Registers are written through csr_wr_en/csr_index/csr_wdata only while idle;
// the user must keep to this, the block does not enforce it. A step counter walks
// an 11-word control program; all five gain products share one 24x18 multiplier
// followed by a 64-bit accumulator. The result becomes valid in the same cycle that
// req_ready rises again, and the next transaction can be accepted from then on.
// A finished result waits in the rsp_ register while the
// next transaction is accepted and worked on; if the receiver still stalls when
// that next result is ready, the program holds on its last step until rsp_ready.
// Synchronous reset clears the program counter, the filter and integral state,
// drops rsp_valid and loads the register reset values.
module cascaded_position_velocity_pid import cpvpid_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_distance,
   input  logic signed [15:0] req_left_count,
   input  logic signed [15:0] req_right_count,
   input  logic signed [15:0] req_accel_x,
   input  logic [7:0]         req_target_x,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_motor_drive,
   output logic signed [31:0] rsp_outer_output,
   output logic               rsp_turn_request,
   output logic signed [1:0]  rsp_turn_direction,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   function automatic logic signed [LP_W-1:0] div10(input logic signed [LP_W-1:0] n);
      logic [LP_W-1:0]    mag;
      logic [LP_W+19:0]   p;
      logic [LP_W-1:0]    q;
      mag = n[LP_W-1] ? (~n + 1'b1) : n;
      p = (LP_W+20)'(mag) * (LP_W+20)'(DIV10_MULT);
      q = LP_W'(p >> DIV10_SHIFT);
      return n[LP_W-1] ? -$signed(q) : $signed(q);
   endfunction

   logic [9:0]               setpoint_ff;
   logic signed [GAIN_W-1:0] pos_kp_ff, pos_ki_ff, spd_kp_ff, spd_kd_ff;
   logic [14:0]              int_limit_ff;
   logic [7:0]               band_low_ff, band_high_ff;

   step_type                 step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [10:0]       fpe_ff, fpe_in;
   logic signed [15:0]       integ_ff, integ_in;
   logic signed [17:0]       fspd_ff, fspd_in;
   logic signed [LP_W-1:0]   lp_num_ff, lp_num_in;
   logic signed [15:0]       encl_ff, encl_in, encr_ff, encr_in, accel_ff, accel_in;
   logic                     turn_req_ff, turn_req_in;
   logic [1:0]               turn_dir_ff, turn_dir_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [32:0]       diff_ff, diff_in;
   logic signed [31:0]       drive_ff, drive_in, outer_ff, outer_in;
   logic signed [31:0]       rsp_outer_ff, rsp_outer_in;
   logic                     rsp_turn_req_ff, rsp_turn_req_in;
   logic [1:0]               rsp_turn_dir_ff, rsp_turn_dir_in;

   ctrl_word_type            ctrl;
   logic                     stay;
   logic                     accept;
   logic signed [GAIN_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [ACC_W-1:0]  prod_ext, prod_sh;
   logic signed [10:0]       err;
   logic signed [16:0]       vel;
   logic signed [LP_W-1:0]   lp_q;
   logic signed [16:0]       isum, ilim;
   logic signed [ACC_W-1:0]  outer_q, drive_q, drive_neg;

   assign req_ready          = (step_ff == STEP_IDLE);
   assign accept             = req_valid && req_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motor_drive    = drive_ff;
   assign rsp_outer_output   = rsp_outer_ff;
   assign rsp_turn_request   = rsp_turn_req_ff;
   assign rsp_turn_direction = rsp_turn_dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= RST_SETPOINT;
         pos_kp_ff    <= RST_POS_KP;
         pos_ki_ff    <= RST_GAIN_ZERO;
         spd_kp_ff    <= RST_GAIN_ZERO;
         spd_kd_ff    <= RST_GAIN_ZERO;
         int_limit_ff <= RST_INT_LIMIT;
         band_low_ff  <= RST_BAND_LOW;
         band_high_ff <= RST_BAND_HIGH;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_SETPOINT:  setpoint_ff  <= csr_wdata[9:0];
            CSR_POS_KP:    pos_kp_ff    <= csr_wdata;
            CSR_POS_KI:    pos_ki_ff    <= csr_wdata;
            CSR_SPD_KP:    spd_kp_ff    <= csr_wdata;
            CSR_SPD_KD:    spd_kd_ff    <= csr_wdata;
            CSR_INT_LIMIT: int_limit_ff <= csr_wdata[14:0];
            CSR_BAND_LOW:  band_low_ff  <= csr_wdata[7:0];
            CSR_BAND_HIGH: band_high_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ctrl = ucode(step_ff);

      case (ctrl.hold)
         HOLD_REQ: stay = !req_valid;
         HOLD_RSP: stay = rsp_valid_ff && !rsp_ready;
         default:  stay = 1'b0;
      endcase
      step_in = stay ? step_ff : ctrl.next;

      case (ctrl.ma)
         MA_POS_KP: mul_a = pos_kp_ff;
         MA_POS_KI: mul_a = pos_ki_ff;
         MA_SPD_KP: mul_a = spd_kp_ff;
         MA_SPD_KD: mul_a = spd_kd_ff;
         default:   mul_a = pos_kp_ff;
      endcase
      case (ctrl.mb)
         MB_FPE:     mul_b = MULB_W'(fpe_ff);
         MB_INTEG:   mul_b = MULB_W'(integ_ff);
         MB_ACCEL:   mul_b = MULB_W'(accel_ff);
         MB_DIFF_LO: mul_b = $signed({2'b00, diff_ff[15:0]});
         MB_DIFF_HI: mul_b = $signed({diff_ff[32], diff_ff[32:16]});
         default:    mul_b = MULB_W'(fpe_ff);
      endcase
      prod_in = PROD_W'(mul_a * mul_b);

      prod_ext = ACC_W'(prod_ff);
      case (ctrl.sh)
         SH_8:    prod_sh = prod_ext <<< 8;
         SH_24:   prod_sh = prod_ext <<< 24;
         default: prod_sh = prod_ext;
      endcase
      case (ctrl.acc)
         ACC_LOAD: acc_in = prod_sh;
         ACC_ADD:  acc_in = acc_ff + prod_sh;
         default:  acc_in = acc_ff;
      endcase

      err = $signed({1'b0, req_distance}) - $signed({1'b0, setpoint_ff});
      vel = $signed({encl_ff[15], encl_ff}) + $signed({encr_ff[15], encr_ff});
      lp_q = div10(lp_num_ff);
      isum = 17'(integ_ff) + 17'(fpe_ff);
      ilim = $signed({2'b00, int_limit_ff});

      outer_q = (acc_ff >>> 8)
              + $signed(ACC_W'({1'b0, acc_ff[ACC_W-1] && (acc_ff[7:0] != 8'd0)}));
      drive_q = (acc_ff >>> 16)
              + $signed(ACC_W'({1'b0, acc_ff[ACC_W-1] && (acc_ff[15:0] != 16'd0)}));
      drive_neg = -drive_q;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      fpe_in          = fpe_ff;
      integ_in        = integ_ff;
      fspd_in         = fspd_ff;
      lp_num_in       = lp_num_ff;
      encl_in         = encl_ff;
      encr_in         = encr_ff;
      accel_in        = accel_ff;
      turn_req_in     = turn_req_ff;
      turn_dir_in     = turn_dir_ff;
      diff_in         = diff_ff;
      drive_in        = drive_ff;
      outer_in        = outer_ff;
      rsp_outer_in    = rsp_outer_ff;
      rsp_turn_req_in = rsp_turn_req_ff;
      rsp_turn_dir_in = rsp_turn_dir_ff;

      case (ctrl.act)
         ACT_CAPTURE: begin
            if (accept) begin
               encl_in   = req_left_count;
               encr_in   = req_right_count;
               accel_in  = req_accel_x;
               lp_num_in = LP_W'(err) * 21'sd3 + LP_W'(fpe_ff) * 21'sd7;
               if (req_target_x < band_low_ff) begin
                  turn_req_in = 1'b1;
                  turn_dir_in = TURN_LEFT;
               end else if (req_target_x > band_high_ff) begin
                  turn_req_in = 1'b1;
                  turn_dir_in = TURN_RIGHT;
               end else begin
                  turn_req_in = 1'b0;
                  turn_dir_in = TURN_NONE;
               end
            end
         end
         ACT_LP_POS: begin
            fpe_in    = lp_q[10:0];
            lp_num_in = LP_W'(vel) * 21'sd3 + LP_W'(fspd_ff) * 21'sd7;
         end
         ACT_LP_SPD: begin
            fspd_in = lp_q[17:0];
            if (isum > ilim) begin
               integ_in = ilim[15:0];
            end else if (isum < -ilim) begin
               integ_in = 16'(-ilim);
            end else begin
               integ_in = isum[15:0];
            end
         end
         ACT_OUTER: begin
            outer_in = outer_q[31:0];
            diff_in  = 33'(fspd_ff) - 33'($signed(outer_q[31:0]));
         end
         ACT_FINISH: begin
            if (!stay) begin
               rsp_valid_in    = 1'b1;
               rsp_outer_in    = outer_ff;
               rsp_turn_req_in = turn_req_ff;
               rsp_turn_dir_in = turn_dir_ff;
               if (drive_neg > 64'sh7FFF_FFFF) begin
                  drive_in = 32'sh7FFF_FFFF;
               end else if (drive_neg < -64'sh8000_0000) begin
                  drive_in = 32'sh8000_0000;
               end else begin
                  drive_in = drive_neg[31:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         fpe_ff       <= '0;
         integ_ff     <= '0;
         fspd_ff      <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         fpe_ff       <= fpe_in;
         integ_ff     <= integ_in;
         fspd_ff      <= fspd_in;
      end
   end

   always_ff @(posedge clock) begin
      lp_num_ff       <= lp_num_in;
      encl_ff         <= encl_in;
      encr_ff         <= encr_in;
      accel_ff        <= accel_in;
      turn_req_ff     <= turn_req_in;
      turn_dir_ff     <= turn_dir_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      diff_ff         <= diff_in;
      drive_ff        <= drive_in;
      outer_ff        <= outer_in;
      rsp_outer_ff    <= rsp_outer_in;
      rsp_turn_req_ff <= rsp_turn_req_in;
      rsp_turn_dir_ff <= rsp_turn_dir_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (step_ff == STEP_LP_POS))
      else $error("accepted transaction did not start the program");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_FINISH)
      else $error("step counter left the program");

   a_fpe_range: assert property (@(posedge clock) disable iff (reset)
      (fpe_ff >= -11'sd1023) && (fpe_ff <= 11'sd1023))
      else $error("filtered position error out of range");

   a_turn_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_turn_request == (rsp_turn_dir_ff != TURN_NONE)))
      else $error("turn request disagrees with direction");

   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_FINISH && !(rsp_valid_ff && !rsp_ready)) |=> rsp_valid_ff)
      else $error("finished transaction not presented");

endmodule

// File: tb/sv/testbench.sv
// testbench: cascaded position/velocity controller against a cycle-free predictor
`timescale 1ns / 100ps

module testbench import cpvpid_pkg::*; ();

   localparam int     RANDOM_ITEMS = 532;
   localparam int     STALL_LIMIT  = 3000;
   localparam longint DRIVE_MAX    = 64'sd2147483647;
   localparam longint DRIVE_MIN    = -64'sd2147483648;

   typedef struct {
      logic [9:0]         distance;
      logic signed [15:0] left_count;
      logic signed [15:0] right_count;
      logic signed [15:0] accel_x;
      logic [7:0]         target_x;
   } tick_fields_type;

   typedef struct {
      logic signed [31:0] motor_drive;
      logic signed [31:0] outer_output;
      logic               turn_request;
      logic signed [1:0]  turn_direction;
   } motor_cmd_type;

   typedef struct {
      bit              is_write;
      logic [2:0]      reg_idx;
      logic [23:0]     wdata;
      tick_fields_type tick;
      bit              known;
      motor_cmd_type   result;
   } plan_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [9:0]         req_distance;
   logic signed [15:0] req_left_count;
   logic signed [15:0] req_right_count;
   logic signed [15:0] req_accel_x;
   logic [7:0]         req_target_x;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_motor_drive;
   logic signed [31:0] rsp_outer_output;
   logic               rsp_turn_request;
   logic signed [1:0]  rsp_turn_direction;
   logic               csr_wr_en;
   logic [2:0]         csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   // predictor copy of the registers and the loop state
   logic [9:0]  cfg_setpoint;
   longint      cfg_pos_kp;
   longint      cfg_pos_ki;
   longint      cfg_spd_kp;
   longint      cfg_spd_kd;
   logic [14:0] cfg_int_limit;
   logic [7:0]  cfg_band_low;
   logic [7:0]  cfg_band_high;
   longint      lp_err_state;
   longint      err_sum;
   longint      lp_speed_state;

   motor_cmd_type pending_cmds[$];
   plan_row_type  directed[$];
   int            fail_count = 0;
   int            stall_cycles = 0;
   bit            calm;

   cascaded_position_velocity_pid u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_distance       (req_distance),
      .req_left_count     (req_left_count),
      .req_right_count    (req_right_count),
      .req_accel_x        (req_accel_x),
      .req_target_x       (req_target_x),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_motor_drive    (rsp_motor_drive),
      .rsp_outer_output   (rsp_outer_output),
      .rsp_turn_request   (rsp_turn_request),
      .rsp_turn_direction (rsp_turn_direction),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void store_reg(input csr_idx_type idx, input logic [23:0] value);
      case (idx)
         CSR_SETPOINT:  cfg_setpoint = value[9:0];
         CSR_POS_KP:    cfg_pos_kp = longint'($signed(value));
         CSR_POS_KI:    cfg_pos_ki = longint'($signed(value));
         CSR_SPD_KP:    cfg_spd_kp = longint'($signed(value));
         CSR_SPD_KD:    cfg_spd_kd = longint'($signed(value));
         CSR_INT_LIMIT: cfg_int_limit = value[14:0];
         CSR_BAND_LOW:  cfg_band_low = value[7:0];
         CSR_BAND_HIGH: cfg_band_high = value[7:0];
         default: ;
      endcase
   endfunction

   function automatic motor_cmd_type control_tick(input tick_fields_type t);
      motor_cmd_type c;
      longint        err;
      longint        integ;
      longint        outer;
      longint        vel;
      longint        inner;
      longint        drive;
      err = longint'(t.distance) - longint'(cfg_setpoint);
      lp_err_state = (3 * err + 7 * lp_err_state) / 10;
      integ = err_sum + lp_err_state;
      if (integ > longint'(cfg_int_limit)) integ = longint'(cfg_int_limit);
      if (integ < -longint'(cfg_int_limit)) integ = -longint'(cfg_int_limit);
      err_sum = integ;
      outer = (cfg_pos_kp * lp_err_state + cfg_pos_ki * integ) / 256;
      vel = longint'(t.left_count) + longint'(t.right_count);
      lp_speed_state = (3 * vel + 7 * lp_speed_state) / 10;
      inner = cfg_spd_kp * lp_speed_state * 256 + cfg_spd_kd * longint'(t.accel_x)
            - cfg_spd_kp * outer * 256;
      drive = -(inner / 65536);
      if (drive > DRIVE_MAX) drive = DRIVE_MAX;
      if (drive < DRIVE_MIN) drive = DRIVE_MIN;
      c.motor_drive = drive[31:0];
      c.outer_output = outer[31:0];
      c.turn_request = 1'b0;
      c.turn_direction = TURN_NONE;
      if (t.target_x < cfg_band_low) begin
         c.turn_request = 1'b1;
         c.turn_direction = TURN_LEFT;
      end else if (t.target_x > cfg_band_high) begin
         c.turn_request = 1'b1;
         c.turn_direction = TURN_RIGHT;
      end
      return c;
   endfunction

   function automatic tick_fields_type make_tick(input int d, input int el, input int er,
                                                 input int ax, input int tx);
      tick_fields_type t;
      t.distance = 10'(d);
      t.left_count = 16'(el);
      t.right_count = 16'(er);
      t.accel_x = 16'(ax);
      t.target_x = 8'(tx);
      return t;
   endfunction

   function automatic plan_row_type tick_row(input int d, input int el, input int er,
                                             input int ax, input int tx);
      plan_row_type r;
      r = '{default: '0};
      r.tick = make_tick(d, el, er, ax, tx);
      return r;
   endfunction

   // drive and outer output read as zero here: no position error, zero speed gains
   function automatic plan_row_type known_row(input int d, input int el, input int er,
                                              input int ax, input int tx,
                                              input logic req, input logic [1:0] dir);
      plan_row_type r;
      r = tick_row(d, el, er, ax, tx);
      r.known = 1'b1;
      r.result.motor_drive = '0;
      r.result.outer_output = '0;
      r.result.turn_request = req;
      r.result.turn_direction = dir;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input csr_idx_type idx, input logic [23:0] value);
      plan_row_type r;
      r = '{default: '0};
      r.is_write = 1'b1;
      r.reg_idx = idx;
      r.wdata = value;
      return r;
   endfunction

   function automatic logic [23:0] gain_value();
      logic [23:0] v;
      case ($urandom_range(5))
         0: v = 24'h7FFFFF;
         1: v = 24'h800000;
         2: v = 24'h000000;
         5: v = 24'($urandom);
         default: v = 24'(int'($urandom_range(4096)) - 2048);
      endcase
      return v;
   endfunction

   function automatic logic [23:0] reg_value(input csr_idx_type idx);
      logic [23:0] v;
      v = 24'($urandom);
      case (idx)
         CSR_SETPOINT: begin
            case ($urandom_range(3))
               0: v[9:0] = 10'd0;
               1: v[9:0] = 10'd1023;
               default: ;
            endcase
         end
         CSR_INT_LIMIT: begin
            case ($urandom_range(3))
               0: v[14:0] = 15'd0;
               1: v[14:0] = 15'd32767;
               2: v[14:0] = 15'($urandom_range(2000, 1));
               default: ;
            endcase
         end
         CSR_BAND_LOW, CSR_BAND_HIGH: begin
            case ($urandom_range(3))
               0: v[7:0] = 8'd0;
               1: v[7:0] = 8'd255;
               2: v[7:0] = 8'($urandom_range(130, 90));
               default: ;
            endcase
         end
         default: v = gain_value();
      endcase
      return v;
   endfunction

   function automatic tick_fields_type random_tick();
      tick_fields_type t;
      int              d;
      t = make_tick(0, 0, 0, 0, 0);
      if ($urandom_range(3) == 0) begin
         t.distance = 10'($urandom);
      end else begin
         d = int'(cfg_setpoint) + int'($urandom_range(80)) - 40;
         if (d < 0) d = 0;
         if (d > 1023) d = 1023;
         t.distance = 10'(d);
      end
      if ($urandom_range(1)) begin
         t.left_count = 16'($urandom);
         t.right_count = 16'($urandom);
      end else begin
         t.left_count = 16'(int'($urandom_range(400)) - 200);
         t.right_count = 16'(int'($urandom_range(400)) - 200);
      end
      t.accel_x = 16'($urandom);
      case ($urandom_range(5))
         0: t.target_x = cfg_band_low - 8'd1;
         1: t.target_x = cfg_band_low;
         2: t.target_x = cfg_band_high;
         3: t.target_x = cfg_band_high + 8'd1;
         default: t.target_x = 8'($urandom);
      endcase
      return t;
   endfunction

   // leaves csr_wr_en high; the caller lowers it after the last write
   task automatic write_reg(input csr_idx_type idx, input logic [23:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      store_reg(idx, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_cmds.size() == 0);
      @(posedge clock);
   endtask

   task automatic send_tick(input tick_fields_type t, input bit known,
                            input motor_cmd_type typed);
      motor_cmd_type predicted;
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_distance <= t.distance;
      req_left_count <= t.left_count;
      req_right_count <= t.right_count;
      req_accel_x <= t.accel_x;
      req_target_x <= t.target_x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = control_tick(t);
      pending_cmds.push_back(known ? typed : predicted);
   endtask

   always @(posedge clock) begin : check_rsp
      motor_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            $error("unexpected transaction: motor_drive %0d outer_output %0d",
                   rsp_motor_drive, rsp_outer_output);
            fail_count++;
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_motor_drive !== want.motor_drive) begin
               $error("motor_drive: expected %0d, actual %0d",
                      want.motor_drive, rsp_motor_drive);
               fail_count++;
            end
            if (rsp_outer_output !== want.outer_output) begin
               $error("outer_output: expected %0d, actual %0d",
                      want.outer_output, rsp_outer_output);
               fail_count++;
            end
            if (rsp_turn_request !== want.turn_request) begin
               $error("turn_request: expected %0d, actual %0d",
                      want.turn_request, rsp_turn_request);
               fail_count++;
            end
            if (rsp_turn_direction !== want.turn_direction) begin
               $error("turn_direction: expected %0d, actual %0d",
                      want.turn_direction, rsp_turn_direction);
               fail_count++;
            end
         end
      end
      rsp_ready <= calm || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      motor_cmd_type blank;
      bit            writing;
      int            random_sent;
      int            phase;
      int            run_len;
      blank = '{default: '0};
      writing = 1'b0;
      random_sent = 0;
      phase = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_distance = '0;
      req_left_count = '0;
      req_right_count = '0;
      req_accel_x = '0;
      req_target_x = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      store_reg(CSR_SETPOINT, 24'(RST_SETPOINT));
      store_reg(CSR_POS_KP, RST_POS_KP);
      store_reg(CSR_POS_KI, RST_GAIN_ZERO);
      store_reg(CSR_SPD_KP, RST_GAIN_ZERO);
      store_reg(CSR_SPD_KD, RST_GAIN_ZERO);
      store_reg(CSR_INT_LIMIT, 24'(RST_INT_LIMIT));
      store_reg(CSR_BAND_LOW, 24'(RST_BAND_LOW));
      store_reg(CSR_BAND_HIGH, 24'(RST_BAND_HIGH));
      lp_err_state = 0;
      err_sum = 0;
      lp_speed_state = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: band edges and field extremes
      directed.push_back(known_row(0, 0, 0, 0, 110, 1'b0, TURN_NONE));
      directed.push_back(known_row(0, 32767, 32767, 32767, 0, 1'b1, TURN_LEFT));
      directed.push_back(known_row(0, -32768, -32768, -32768, 255, 1'b1, TURN_RIGHT));
      directed.push_back(known_row(0, 0, 0, 0, 104, 1'b1, TURN_LEFT));
      directed.push_back(known_row(0, 0, 0, 0, 105, 1'b0, TURN_NONE));
      directed.push_back(known_row(0, 0, 0, 0, 115, 1'b0, TURN_NONE));
      directed.push_back(known_row(0, 0, 0, 0, 116, 1'b1, TURN_RIGHT));
      directed.push_back(tick_row(1023, 0, 0, 0, 110));
      // gain extremes, zero integral clamp, inverted band
      directed.push_back(csr_row(CSR_SETPOINT, 24'h0003FF));
      directed.push_back(csr_row(CSR_POS_KP, 24'h7FFFFF));
      directed.push_back(csr_row(CSR_POS_KI, 24'h800000));
      directed.push_back(csr_row(CSR_SPD_KP, 24'h7FFFFF));
      directed.push_back(csr_row(CSR_SPD_KD, 24'h800000));
      directed.push_back(csr_row(CSR_INT_LIMIT, 24'h000000));
      directed.push_back(csr_row(CSR_BAND_LOW, 24'h0000C8));
      directed.push_back(csr_row(CSR_BAND_HIGH, 24'h000032));
      directed.push_back(tick_row(0, 32767, 32767, 32767, 100));
      directed.push_back(tick_row(0, -32768, -32768, -32768, 255));
      directed.push_back(tick_row(1023, 32767, -32768, 0, 200));
      directed.push_back(tick_row(0, 0, 0, -32768, 0));
      // opposite gain extremes, junk in the upper write bits, band covering all x
      directed.push_back(csr_row(CSR_SETPOINT, 24'hABC200));
      directed.push_back(csr_row(CSR_POS_KP, 24'h800000));
      directed.push_back(csr_row(CSR_POS_KI, 24'h7FFFFF));
      directed.push_back(csr_row(CSR_SPD_KP, 24'h800000));
      directed.push_back(csr_row(CSR_SPD_KD, 24'h7FFFFF));
      directed.push_back(csr_row(CSR_INT_LIMIT, 24'hFF82BC));
      directed.push_back(csr_row(CSR_BAND_LOW, 24'h123400));
      directed.push_back(csr_row(CSR_BAND_HIGH, 24'hFFFFFF));
      directed.push_back(tick_row(1023, 32767, 32767, 32767, 0));
      directed.push_back(tick_row(0, -32768, -32768, -32768, 255));
      directed.push_back(tick_row(1023, 100, 100, 32767, 128));
      directed.push_back(tick_row(1023, -100, 50, -32768, 1));
      directed.push_back(tick_row(1023, 0, 0, 0, 254));
      directed.push_back(tick_row(0, 21845, -21846, 21845, 85));

      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            if (!writing) begin
               drain();
               writing = 1'b1;
            end
            write_reg(csr_idx_type'(directed[i].reg_idx), directed[i].wdata);
         end else begin
            if (writing) begin
               csr_wr_en <= 1'b0;
               writing = 1'b0;
            end
            send_tick(directed[i].tick, directed[i].known, directed[i].result);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         drain();
         for (int k = 0; k < 8; k++) begin
            if ($urandom_range(1)) write_reg(csr_idx_type'(k), reg_value(csr_idx_type'(k)));
         end
         csr_wr_en <= 1'b0;
         calm = (phase == 3);
         run_len = $urandom_range(70, 25);
         if (run_len > RANDOM_ITEMS - random_sent) run_len = RANDOM_ITEMS - random_sent;
         repeat (run_len) begin
            send_tick(random_tick(), 1'b0, blank);
            random_sent++;
         end
         phase++;
      end

      calm = 1'b0;
      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
